// ===== src/rs_pkg.sv =====
// ----------------------------------------------------------------------------
// rs_pkg
// shared types and constants of the reservoir sampler
// ----------------------------------------------------------------------------
package rs_pkg;

    // field widths
    localparam int TAG_W  = 32;
    localparam int SLOT_W = 12;
    localparam int KEPT_W = 13;
    localparam int RNG_W  = 64;

    // stream widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    // output tdata field positions
    localparam int KEEP_POS = 0;
    localparam int SLOT_POS = KEEP_POS + 1;
    localparam int REPL_POS = SLOT_POS + SLOT_W;
    localparam int TAG_POS  = REPL_POS + 1;
    localparam int KEPT_POS = TAG_POS + TAG_W;
    localparam int PAD_W    = OUT_DATA_W - (KEPT_POS + KEPT_W);

    // configuration port
    localparam int                 CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 1'b1;
    localparam logic [KEPT_W-1:0]  LIMIT_RESET      = 13'd4096;

    // xorshift shifts
    localparam int SH_A = 13;
    localparam int SH_B = 7;
    localparam int SH_C = 17;

    // serial modulo: one dividend bit per cycle
    localparam int DIV_STEPS = RNG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== src/rs_xorshift.sv =====
// ----------------------------------------------------------------------------
// rs_xorshift
// 64-bit xorshift generator state with load and step
// ----------------------------------------------------------------------------
module rs_xorshift (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [rs_pkg::RNG_W-1:0] i_load_value,
    input  logic                     i_step,
    output logic [rs_pkg::RNG_W-1:0] o_state,
    output logic [rs_pkg::RNG_W-1:0] o_next
);
    import rs_pkg::*;

    logic [RNG_W-1:0] r_state;
    logic [RNG_W-1:0] x_a;
    logic [RNG_W-1:0] x_b;

    always_comb begin
        x_a    = r_state ^ (r_state << SH_A);
        x_b    = x_a ^ (x_a >> SH_B);
        o_next = x_b ^ (x_b << SH_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_load) begin
            r_state <= i_load_value;
        end else if (i_step) begin
            r_state <= o_next;
        end
    end

    assign o_state = r_state;

endmodule

// ===== src/rs_mod_serial.sv =====
// ----------------------------------------------------------------------------
// rs_mod_serial
// restoring modulo, one dividend bit shifted in per cycle
// ----------------------------------------------------------------------------
module rs_mod_serial #(
    parameter int DEN_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rs_pkg::RNG_W-1:0] i_dividend,
    input  logic [DEN_W-1:0]         i_divisor,
    output rs_pkg::t_div_status      o_status,
    output logic [DEN_W-1:0]         o_rem
);
    import rs_pkg::*;

    logic [RNG_W-1:0]     r_src;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic [DEN_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_src[RNG_W-1]};
        diff  = trial - {1'b0, r_den};
        // remainder stays below the divisor, so the top bit drops out
        n_rem = (trial >= {1'b0, r_den}) ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_src <= {r_src[RNG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_rem         = r_rem;

endmodule

// ===== src/reservoir_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// reservoir_sampler_unit
// algorithm r reservoir sampling decision with a xorshift64 generator
// ----------------------------------------------------------------------------
// Each input transaction offers one item tag and produces exactly one output
// transaction saying whether the item is kept, in which slot, and whether it
// overwrites an earlier item. While the reservoir is filling an item takes
// the next free slot and its result goes through ST_DONE to the output
// register. Once full (and with a nonzero generator state) the generator
// is stepped and its 64-bit output is reduced modulo the seen count by a
// serial restoring divider that takes one dividend bit per cycle, so such an
// item goes through ST_DIV and ST_DONE to the output register, and no new
// item is accepted while the divider runs; that loop sets the sustained rate.
// With a zero generator state a full reservoir drops items on the fast path.
// The next item is accepted as soon as the previous result has moved to the
// output register, even while it still waits for the downstream side.
// Configuration: index 0 sets sample_limit (0 acts as 1, values above SLOTS
// clip to SLOTS), index 1 loads the seed into the generator; write only
// while idle.
// ----------------------------------------------------------------------------
module reservoir_sampler_unit #(
    parameter int SLOTS     = 4096,
    parameter int SEEN_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [rs_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [rs_pkg::RNG_W-1:0]      i_cfg_wdata,
    // offered items
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // item_tag[31:0]
    // decisions
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // keep[0], slot[12:1], replaces[13], tag_out[45:14], kept_total[58:46],
    // zero[63:59]
    output logic [rs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import rs_pkg::*;

    localparam logic [16:0] SLOTS_W = 17'(SLOTS);

    t_state              r_state, n_state;
    logic [SEEN_BITS-1:0] r_seen, n_seen;
    logic [KEPT_W-1:0]   r_kept, n_kept;
    logic [KEPT_W-1:0]   r_limit;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic                r_keep, n_keep;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_repl, n_repl;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                in_fire;
    logic                rng_step;
    logic                rng_load;
    logic                div_start;
    logic                out_load;
    logic [RNG_W-1:0]    rng_state;
    logic [RNG_W-1:0]    rng_next;
    t_div_status         div_st;
    logic [SEEN_BITS-1:0] pick;
    logic [SEEN_BITS-1:0] seen_inc;
    logic [KEPT_W-1:0]   lim_eff;
    logic [16:0]         lim_wide;

    // effective limit: zero acts as one, clipped to the slot count
    always_comb begin
        lim_wide = {4'b0, r_limit};
        if (r_limit == '0) begin
            lim_eff = KEPT_W'(1);
        end else if (lim_wide > SLOTS_W) begin
            lim_eff = SLOTS_W[KEPT_W-1:0];
        end else begin
            lim_eff = r_limit;
        end
    end

    // seen count saturates at all ones
    assign seen_inc = (r_seen == '1) ? r_seen : r_seen + SEEN_BITS'(1);

    assign o_s_axis_tready = (r_state == ST_IDLE) && !div_st.busy;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign rng_load        = i_cfg_wr_en && (i_cfg_addr == CFG_SEED);

    rs_xorshift u_rng (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (rng_load),
        .i_load_value (i_cfg_wdata),
        .i_step       (rng_step),
        .o_state      (rng_state),
        .o_next       (rng_next)
    );

    // divisor is the seen count including this item
    rs_mod_serial #(
        .DEN_W (SEEN_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rng_next),
        .i_divisor  (n_seen),
        .o_status   (div_st),
        .o_rem      (pick)
    );

    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_kept    = r_kept;
        n_tag     = r_tag;
        n_keep    = r_keep;
        n_slot    = r_slot;
        n_repl    = r_repl;
        rng_step  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_tag  = i_s_axis_tdata[TAG_W-1:0];
                    n_seen = seen_inc;
                    if (r_kept < lim_eff) begin
                        // still filling: next free slot
                        n_keep  = 1'b1;
                        n_slot  = r_kept[SLOT_W-1:0];
                        n_repl  = 1'b0;
                        n_kept  = r_kept + KEPT_W'(1);
                        n_state = ST_DONE;
                    end else if (rng_state != '0) begin
                        // full: step generator, reduce modulo seen count
                        rng_step  = 1'b1;
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end else begin
                        // full with zero generator: drop
                        n_keep  = 1'b0;
                        n_slot  = '0;
                        n_repl  = 1'b0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    if (pick < {{(SEEN_BITS-KEPT_W){1'b0}}, lim_eff}) begin
                        n_keep = 1'b1;
                        n_slot = pick[SLOT_W-1:0];
                        n_repl = 1'b1;
                    end else begin
                        n_keep = 1'b0;
                        n_slot = '0;
                        n_repl = 1'b0;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= '0;
            r_kept      <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_kept  <= n_kept;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_SAMPLE_LIMIT: r_limit <= i_cfg_wdata[KEPT_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_keep <= n_keep;
        r_slot <= n_slot;
        r_repl <= n_repl;
        if (out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, r_kept, r_tag, r_repl, r_slot, r_keep};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== src/rs_checker.sv =====
// ----------------------------------------------------------------------------
// rs_checker
// port-level checks on the reservoir sampler decision stream
// ----------------------------------------------------------------------------
module rs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [rs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import rs_pkg::*;

    localparam int KPT_LO = KEPT_POS;

    logic              keep;
    logic              repl;
    logic [SLOT_W-1:0] slot;
    logic [KEPT_W-1:0] kept;

    assign keep = o_m_axis_tdata[KEEP_POS];
    assign repl = o_m_axis_tdata[REPL_POS];
    assign slot = o_m_axis_tdata[SLOT_POS +: SLOT_W];
    assign kept = o_m_axis_tdata[KPT_LO +: KEPT_W];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // no result straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a dropped item names no slot and no overwrite
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !keep |-> (slot == '0) && !repl)
        else $error("dropped item carries slot or replace flag");

    // a fresh slot is the last filled one
    a_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && keep && !repl |-> kept[SLOT_W-1:0] == SLOT_W'(slot + 1'b1))
        else $error("fresh slot does not match fill count");

endmodule

bind reservoir_sampler_unit rs_checker u_rs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the reservoir sampler decision unit
// ----------------------------------------------------------------------------
// A directed table first covers reset fill, limit clipping, zero limit, a limit
// lowered below the fill, zero and all-ones seeds and the drop path. Random
// phases then follow, each in one of four idling modes, some with a fresh
// setting. Every accepted decision is compared field by field with its typed
// row, else with a local copy of the sampling algorithm advanced per item.
// ----------------------------------------------------------------------------
module tb;

    import rs_pkg::*;

    localparam int SLOTS         = 4096;
    localparam int ITEMS_TARGET  = 1800;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 200;

    // decision as packed on the output stream, keep in bit 0
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [KEPT_W-1:0] kept;
        logic [TAG_W-1:0]  tag;
        logic              repl;
        logic [SLOT_W-1:0] slot;
        logic              keep;
    } t_decision;

    typedef struct {
        bit                   wr;
        logic [CFG_IDX_W-1:0] addr;
        logic [RNG_W-1:0]     wdata;
        bit                   offer;
        logic [TAG_W-1:0]     tag;
        bit                   typed;
        t_decision            dec;
    } t_row;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = CFG_SAMPLE_LIMIT;
    logic [RNG_W-1:0]       cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic [IN_DATA_W-1:0]   s_data    = '0;
    logic                   m_ready   = 1'b0;
    wire                    s_ready;
    wire                    m_valid;
    wire  [OUT_DATA_W-1:0]  m_data;

    // local copy of the sampler state and settings
    logic [KEPT_W-1:0]  limit_q = LIMIT_RESET;
    logic [31:0]        seen_q  = '0;
    logic [KEPT_W-1:0]  kept_q  = '0;
    logic [RNG_W-1:0]   gen_q   = '0;

    t_decision pending_decisions [$];
    t_row      dir_tab [$];
    int        errors         = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        quiet_cycles   = 0;

    always #1 clk = ~clk;

    reservoir_sampler_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // one sampling decision, advancing the local state
    function automatic t_decision decide_item(input logic [TAG_W-1:0] tag);
        logic [KEPT_W-1:0] lim;
        logic [RNG_W-1:0]  x;
        logic [RNG_W-1:0]  pick;
        t_decision         d;
        d     = '0;
        d.tag = tag;
        lim   = (limit_q == '0) ? KEPT_W'(1) :
                (limit_q > KEPT_W'(SLOTS)) ? KEPT_W'(SLOTS) : limit_q;
        if (seen_q != '1)
            seen_q = seen_q + 1'b1;
        if (kept_q < lim) begin
            d.keep = 1'b1;
            d.slot = kept_q[SLOT_W-1:0];
            kept_q = kept_q + 1'b1;
        end else if (gen_q != '0) begin
            x = gen_q;
            x = x ^ (x << SH_A);
            x = x ^ (x >> SH_B);
            x = x ^ (x << SH_C);
            gen_q = x;
            pick  = x % RNG_W'(seen_q);
            if (pick < RNG_W'(lim)) begin
                d.keep = 1'b1;
                d.slot = pick[SLOT_W-1:0];
                d.repl = 1'b1;
            end
        end
        d.kept = kept_q;
        return d;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic t_row row_cfg(input logic [CFG_IDX_W-1:0] a,
                                     input logic [RNG_W-1:0] d);
        t_row r;
        r       = '{default: '0};
        r.wr    = 1'b1;
        r.addr  = a;
        r.wdata = d;
        return r;
    endfunction

    function automatic t_row row_item(input logic [TAG_W-1:0] tag);
        t_row r;
        r       = '{default: '0};
        r.offer = 1'b1;
        r.tag   = tag;
        return r;
    endfunction

    function automatic t_row row_typed(input logic [TAG_W-1:0] tag, input logic k,
                                       input logic [SLOT_W-1:0] s, input logic rp,
                                       input logic [KEPT_W-1:0] kt);
        t_row r;
        r          = row_item(tag);
        r.typed    = 1'b1;
        r.dec      = '0;
        r.dec.keep = k;
        r.dec.slot = s;
        r.dec.repl = rp;
        r.dec.tag  = tag;
        r.dec.kept = kt;
        return r;
    endfunction

    // hold the input side until every outstanding decision has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input logic [RNG_W-1:0] d);
        drain_results();
        cfg_wr    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_wr    <= 1'b0;
        if (a == CFG_SAMPLE_LIMIT)
            limit_q = d[KEPT_W-1:0];
        else if (a == CFG_SEED)
            gen_q = d;
    endtask

    // offer one item, then record what it should produce
    task automatic send_item(input logic [TAG_W-1:0] tag, input bit typed,
                             input t_decision typed_dec);
        t_decision want;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= tag;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        want = decide_item(tag);
        pending_decisions.push_back(typed ? typed_dec : want);
    endtask

    // output side: check each transaction, then pick the next ready
    always @(posedge clk) begin
        t_decision got;
        t_decision want;
        if (rst_n && m_valid && m_ready) begin
            got = m_data;
            if (pending_decisions.size() == 0) begin
                $display("%0t: unexpected decision, expected none, got %0h", $time, got);
                errors++;
            end else begin
                want = pending_decisions.pop_front();
                check_field("keep", 64'(want.keep), 64'(got.keep));
                check_field("slot", 64'(want.slot), 64'(got.slot));
                check_field("replaces", 64'(want.repl), 64'(got.repl));
                check_field("tag_out", 64'(want.tag), 64'(got.tag));
                check_field("kept_total", 64'(want.kept), 64'(got.kept));
                check_field("padding", 64'(want.pad), 64'(got.pad));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction or register write
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int                sent;
        int                phase;
        int                n;
        logic [KEPT_W-1:0] lim;
        logic [RNG_W-1:0]  rnd;
        t_decision         none;

        none  = '0;
        sent  = 0;
        phase = 0;

        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill from reset with the default limit
        dir_tab.push_back(row_typed(32'h0000_0000, 1'b1, 12'd0, 1'b0, 13'd2 - 13'd1));
        dir_tab.push_back(row_typed(32'hFFFF_FFFF, 1'b1, 12'd1, 1'b0, 13'd2));
        // zero limit acts as one, already below the fill, zero generator drops
        dir_tab.push_back(row_cfg(CFG_SAMPLE_LIMIT, 64'd0));
        dir_tab.push_back(row_typed(32'h5555_5555, 1'b0, 12'd0, 1'b0, 13'd2));
        // smallest nonzero seed on the sampling path
        dir_tab.push_back(row_cfg(CFG_SEED, 64'd1));
        dir_tab.push_back(row_item(32'h0000_0001));
        dir_tab.push_back(row_item(32'h8000_0000));
        dir_tab.push_back(row_item(32'h1234_5678));
        dir_tab.push_back(row_item(32'hDEAD_BEEF));
        // limit above the slot count clips, so filling resumes
        dir_tab.push_back(row_cfg(CFG_SAMPLE_LIMIT, 64'h1FFF));
        dir_tab.push_back(row_typed(32'h0F0F_0F0F, 1'b1, 12'd2, 1'b0, 13'd3));
        dir_tab.push_back(row_cfg(CFG_SAMPLE_LIMIT, 64'd3));
        dir_tab.push_back(row_item(32'hAAAA_AAAA));
        dir_tab.push_back(row_item(32'h7654_3210));
        dir_tab.push_back(row_cfg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF));
        dir_tab.push_back(row_item(32'hCAFE_F00D));
        dir_tab.push_back(row_item(32'h0000_FFFF));
        dir_tab.push_back(row_cfg(CFG_SAMPLE_LIMIT, 64'd1));
        dir_tab.push_back(row_item(32'hFFFF_0000));
        dir_tab.push_back(row_cfg(CFG_SAMPLE_LIMIT, 64'd4096));
        dir_tab.push_back(row_typed(32'hF0F0_F0F0, 1'b1, 12'd3, 1'b0, 13'd4));
        // full reservoir with the generator cleared drops on the fast path
        dir_tab.push_back(row_cfg(CFG_SAMPLE_LIMIT, 64'd4));
        dir_tab.push_back(row_cfg(CFG_SEED, 64'd0));
        dir_tab.push_back(row_typed(32'h7FFF_FFFF, 1'b0, 12'd0, 1'b0, 13'd4));
        dir_tab.push_back(row_cfg(CFG_SEED, 64'h8000_0000_0000_0000));
        dir_tab.push_back(row_item(32'h3C3C_C3C3));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].wr)
                write_reg(dir_tab[i].addr, dir_tab[i].wdata);
            if (dir_tab[i].offer)
                send_item(dir_tab[i].tag, dir_tab[i].typed, dir_tab[i].dec);
        end

        // random phases, cycling through the idling modes
        while (sent < ITEMS_TARGET) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase

            // pause the sender until every decision is back
            drain_results();

            if (phase == 0 || $urandom_range(1) == 1) begin
                case ($urandom_range(9))
                    0:       lim = '0;
                    1:       lim = KEPT_W'(1);
                    2:       lim = KEPT_W'(SLOTS);
                    3:       lim = '1;
                    default: lim = KEPT_W'($urandom_range(int'(kept_q) + 4, 1));
                endcase
                rnd = {$urandom, $urandom};
                write_reg(CFG_SAMPLE_LIMIT, {rnd[RNG_W-1:KEPT_W], lim});
            end
            if (phase == 0 || $urandom_range(1) == 1) begin
                case ($urandom_range(7))
                    0:       rnd = '0;
                    1:       rnd = '1;
                    2:       rnd = 64'd1;
                    default: rnd = {$urandom, $urandom};
                endcase
                write_reg(CFG_SEED, rnd);
            end

            n = $urandom_range(120, 40);
            repeat (n) begin
                send_item($urandom, 1'b0, none);
                sent++;
            end
            phase++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
